// ===== sv/cge_pkg.sv =====
// ----------------------------------------------------------------------------
// Color gradient evaluator package
// Request codes, controller command and status bundles.
// ----------------------------------------------------------------------------
package cge_pkg;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_EVAL   = 2'd2;

    typedef struct packed {
        logic load;       // capture the input word
        logic clear;      // empty the table
        logic scan_start; // reset the scan index
        logic scan_step;  // read next entry, compare
        logic shift_step; // move one entry up during insert
        logic ins_write;  // write the new key
        logic div_start;
        logic div_step;
        logic blend;      // form the interpolated color
        logic res_plain;  // result without evaluation color
        logic res_color;  // result from selected color
        logic res_blend;
    } cge_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       empty;
        logic       one_key;
        logic       scan_done;
        logic       hit;
        logic       at_edge;
        logic       shift_done;
        logic       div_done;
    } cge_stat_t;

endpackage

// ===== sv/cge_datapath.sv =====
// ----------------------------------------------------------------------------
// Color gradient datapath
// Key table, sequential segment scan, restoring divider and channel blend.
// ----------------------------------------------------------------------------
module cge_datapath #(
    parameter int MAX_KEYS       = 16,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cge_pkg::cge_cmd_t   cmd,
    output cge_pkg::cge_stat_t  stat,
    input  logic [1:0]          in_req,
    input  logic [TIME_FRAC_BITS:0] in_time,
    input  logic [31:0]         in_color,
    output logic                res_status,
    output logic [31:0]         res_color,
    output logic [$clog2(MAX_KEYS+1)-1:0] res_keys
);
    import cge_pkg::*;

    localparam int TW = TIME_FRAC_BITS + 1;
    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int DIVW = TIME_FRAC_BITS + TW;
    localparam int FW = TIME_FRAC_BITS + 1;
    localparam int DCW = $clog2(DIVW + 1);

    logic [TW-1:0] time_mem [MAX_KEYS];
    logic [31:0]   color_mem [MAX_KEYS];

    logic [CW-1:0] count_reg;
    logic [1:0]    req_reg;
    logic [TW-1:0] t_reg;
    logic [31:0]   col_reg;
    logic [CW-1:0] idx_reg;
    logic [TW-1:0] prev_t_reg, cur_t_reg;
    logic [31:0]   prev_c_reg, cur_c_reg;
    logic [TW-1:0] last_t_reg;
    logic [31:0]   last_c_reg;
    logic [DIVW-1:0] quo_reg;
    logic [TW:0]     rem_reg;
    logic [TW-1:0]   den_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic [FW-1:0]   frac_val;
    logic [31:0]     blend_reg;
    logic            status_reg;
    logic [31:0]     rcol_reg;
    logic [CW-1:0]   idx_m1;
    logic [CW-1:0]   idx_p1;

    assign idx_m1 = idx_reg - CW'(1);
    assign idx_p1 = idx_reg + CW'(1);

    // Table memory: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.shift_step)
        begin
            time_mem[idx_p1[IW-1:0]]  <= cur_t_reg;
            color_mem[idx_p1[IW-1:0]] <= cur_c_reg;
        end
        else if (cmd.ins_write)
        begin
            time_mem[idx_p1[IW-1:0]]  <= t_reg;
            color_mem[idx_p1[IW-1:0]] <= col_reg;
        end
        cur_t_reg <= time_mem[idx_reg[IW-1:0]];
        cur_c_reg <= color_mem[idx_reg[IW-1:0]];
        if (cmd.shift_step || cmd.scan_step)
        begin
            prev_t_reg <= cur_t_reg;
            prev_c_reg <= cur_c_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.ins_write)
                count_reg <= count_reg + CW'(1);
            if (cmd.scan_start)
            begin
                // Insert walks down from the top, evaluate walks up from zero.
                idx_reg <= (req_reg == REQ_INSERT) ? (count_reg - CW'(1)) : '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_p1;
            end
            else if (cmd.shift_step)
            begin
                idx_reg <= idx_m1;
            end
            if (cmd.div_start)
                dcnt_reg <= DCW'(DIVW);
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_req;
            t_reg   <= in_time;
            col_reg <= in_color;
        end
        // A new key lands last when no held key is later than it.
        if (cmd.ins_write && (count_reg == '0 || t_reg >= last_t_reg))
        begin
            last_t_reg <= t_reg;
            last_c_reg <= col_reg;
        end
        if (cmd.div_start)
        begin
            quo_reg <= {t_reg - prev_t_reg, {TIME_FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= cur_t_reg - prev_t_reg;
        end
        else if (cmd.div_step)
        begin
            if ({rem_reg[TW-1:0], quo_reg[DIVW-1]} >= {1'b0, den_reg})
            begin
                rem_reg <= {rem_reg[TW-1:0], quo_reg[DIVW-1]} - {1'b0, den_reg};
                quo_reg <= {quo_reg[DIVW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[TW-1:0], quo_reg[DIVW-1]};
                quo_reg <= {quo_reg[DIVW-2:0], 1'b0};
            end
        end
        if (cmd.blend)
        begin
            for (int k = 0; k < 4; k++)
            begin
                blend_reg[8*k +: 8] <= 8'((
                    (FW+8)'(prev_c_reg[8*k +: 8])
                        * (((FW+8)'(1) << TIME_FRAC_BITS) - (FW+8)'(frac_val))
                    + (FW+8)'(cur_c_reg[8*k +: 8]) * (FW+8)'(frac_val))
                    >> TIME_FRAC_BITS);
            end
        end
        if (cmd.res_plain)
        begin
            status_reg <= (req_reg == REQ_INSERT) && (count_reg == CW'(MAX_KEYS));
            rcol_reg   <= (req_reg == REQ_EVAL) ? 32'hFFFF_FFFF : 32'h0;
        end
        else if (cmd.res_color)
        begin
            // A time past the current entry takes the last key's color.
            status_reg <= 1'b0;
            rcol_reg   <= (t_reg <= cur_t_reg) ? cur_c_reg : last_c_reg;
        end
        else if (cmd.res_blend)
        begin
            status_reg <= 1'b0;
            rcol_reg   <= blend_reg;
        end
    end

    // Clamp the quotient to one; a zero-length segment gives zero.
    always_comb
    begin
        if (den_reg == '0)
            frac_val = '0;
        else if (quo_reg > DIVW'(1) << TIME_FRAC_BITS)
            frac_val = FW'(1) << TIME_FRAC_BITS;
        else
            frac_val = quo_reg[FW-1:0];
    end

    always_comb
    begin
        stat.req        = req_reg;
        stat.full       = (count_reg == CW'(MAX_KEYS));
        stat.empty      = (count_reg == '0);
        stat.one_key    = (count_reg == CW'(1));
        stat.scan_done  = (idx_reg == count_reg);
        stat.at_edge    = (t_reg >= last_t_reg);
        stat.hit        = (t_reg <= cur_t_reg);
        stat.shift_done = (idx_reg == {CW{1'b1}}) || !(cur_t_reg > t_reg);
        stat.div_done   = (dcnt_reg == '0);
    end

    assign res_status = status_reg;
    assign res_color  = rcol_reg;
    assign res_keys   = count_reg;
endmodule

// ===== sv/cge_controller.sv =====
// ----------------------------------------------------------------------------
// Color gradient controller
// Sequences clear, insert shifts, segment scan, division and result capture.
// ----------------------------------------------------------------------------
module cge_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  cge_pkg::cge_stat_t stat,
    output cge_pkg::cge_cmd_t  cmd
);
    import cge_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_IRD    = 4'd2;
    localparam logic [3:0] S_ICHK   = 4'd3;
    localparam logic [3:0] S_ESRD   = 4'd4;
    localparam logic [3:0] S_ECHK   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_BLEND  = 4'd7;
    localparam logic [3:0] S_RBLEND = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_LAST   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_OUT && out_ready);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        first_next = first_reg;
        unique case (state_reg)
            S_IDLE, S_OUT:
            begin
                if (state_reg == S_OUT && out_ready)
                    state_next = S_IDLE;
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.req == REQ_CLEAR)
                begin
                    cmd.clear     = 1'b1;
                    cmd.res_plain = 1'b1;
                    state_next    = S_LAST;
                end
                else if (stat.req == REQ_INSERT && !stat.full)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_IRD;
                end
                else if (stat.req == REQ_EVAL && !stat.empty)
                begin
                    cmd.scan_start = 1'b1;
                    first_next     = 1'b1;
                    state_next     = S_ESRD;
                end
                else
                begin
                    cmd.res_plain = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_IRD: state_next = S_ICHK;  // read of entry idx lands
            S_ICHK:
            begin
                // Move entry idx up while it is later than the new key.
                if (stat.empty || stat.shift_done)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                    state_next     = S_IRD;
                end
            end
            S_ESRD: state_next = S_ECHK;
            S_ECHK:
            begin
                // cur holds entry idx; prev holds entry idx-1 when not first.
                // The first check also settles both ends of the table.
                if (first_reg && (stat.hit || stat.at_edge || stat.one_key))
                begin
                    cmd.res_color = 1'b1;
                    state_next    = S_OUT;
                end
                else if (!first_reg && stat.hit)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (!first_reg && stat.scan_done)
                begin
                    cmd.res_color = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    first_next    = 1'b0;
                    state_next    = S_ESRD;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_BLEND;
                else
                    cmd.div_step = 1'b1;
            end
            S_BLEND:
            begin
                cmd.blend  = 1'b1;
                state_next = S_RBLEND;
            end
            S_RBLEND:
            begin
                cmd.res_blend = 1'b1;
                state_next    = S_OUT;
            end
            S_LAST:
            begin
                if (stat.req == REQ_INSERT)
                    cmd.ins_write = 1'b1;
                cmd.res_plain = 1'b1;
                state_next    = S_OUT;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== sv/color_gradient_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// Color gradient evaluator
// Clear, full insert, empty evaluate and unused codes give a plain result.
// Insert shifts later keys up, then writes. Evaluate at or past an end gives
// that end's color; inside, it scans to the segment, divides bit-serially
// and blends. One word is in flight at a time; the next is taken in the
// cycle its result leaves. Reset clears the key count, not the table.
// ----------------------------------------------------------------------------
module color_gradient_evaluator_unit #(
    parameter int MAX_KEYS       = 16,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type, time_value, red, green, blue, alpha
    input  logic [((TIME_FRAC_BITS + 42) / 8) * 8 - 1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, red, green, blue, alpha, keys_held
    output logic [(($clog2(MAX_KEYS + 1) + 40) / 8) * 8 - 1:0] m_tdata
);
    import cge_pkg::*;

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int OW = ((CW + 40) / 8) * 8;

    cge_cmd_t  cmd;
    cge_stat_t stat;
    logic        r_status;
    logic [31:0] r_color;
    logic [CW-1:0] r_keys;
    logic [TIME_FRAC_BITS:0] t_in;
    logic [31:0] c_in;

    assign t_in = s_tdata[2 +: TIME_FRAC_BITS + 1];
    assign c_in = s_tdata[TIME_FRAC_BITS + 3 +: 32];

    cge_controller u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    cge_datapath #(.MAX_KEYS(MAX_KEYS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_req(s_tdata[1:0]), .in_time(t_in), .in_color(c_in),
        .res_status(r_status), .res_color(r_color), .res_keys(r_keys)
    );

    assign m_tdata = OW'({r_keys, r_color, r_status});
endmodule
